// File: rtl/core/swta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swta_pkg: shared types and codes of the sliding-window tag allocator
// Holds the request and result word layouts, the operation codes and the
// status codes used by the allocator and its checker.
// ----------------------------------------------------------------------------
package swta_pkg;

  // Width of the tag fields as they appear on the ports.
  localparam int TAG_FIELD_W = 16;

  // Operation codes. Any code with bit 1 set behaves as a check.
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_CHECK = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK              = 2'd0;
  localparam logic [1:0] ST_FULL            = 2'd1;
  localparam logic [1:0] ST_INCONSISTENT    = 2'd2;
  localparam logic [1:0] ST_NOT_OUTSTANDING = 2'd3;

  // Request word.
  typedef struct packed {
    logic [1:0]             func;
    logic [TAG_FIELD_W-1:0] tag_in;
  } swta_in_t;

  // Result word.
  typedef struct packed {
    logic [TAG_FIELD_W-1:0] tag_out;
    logic [1:0]             status;
  } swta_out_t;

endpackage

// File: rtl/core/swta_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swta_map: busy bitmap memory
// One bit per tag, one write port and one read port, read data registered.
// A read and a write of the same entry at one edge return the old value.
// ----------------------------------------------------------------------------
module swta_map #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic mem [DEPTH];
  logic rdata_r;

  // Synchronous write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Synchronous read port; the read data is registered.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sliding_window_tag_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_tag_allocator: request tag allocator with a sliding window
// Issues, frees and checks request tags over a busy bitmap held in memory.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Its result
// appears on out_word for exactly one cycle, marked by out_strobe, after
// the execute state and the result register; the receiver cannot stall it.
// Allocate and check raise busy for one cycle, so a new word can be taken
// once the command has left the execute state. Free keeps busy high through
// the execute state and the release walk, in which the oldest pointer steps
// over released tags, reading the bitmap memory one entry per cycle. Bitmap
// entries outside the window from oldest to next are treated as clear, so
// the memory needs no clearing pass after reset and is usable at once.
// ----------------------------------------------------------------------------
module sliding_window_tag_allocator
  import swta_pkg::*;
#(
  parameter int TAG_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  swta_in_t  in_word,
  output logic      out_strobe,
  output swta_out_t out_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  // Window limit: one less than a quarter of the tag space.
  localparam logic [TAG_WIDTH-1:0] TAG_WINDOW =
    TAG_WIDTH'(((1 << TAG_WIDTH) - 1) / 4);

  logic [1:0]           state_r, state_nxt;
  logic [TAG_WIDTH-1:0] next_r, next_nxt;
  logic [TAG_WIDTH-1:0] oldest_r, oldest_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  swta_out_t            out_word_r, out_word_nxt;
  logic [1:0]           func_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic [TAG_WIDTH-1:0] rd_addr_r;

  logic                 mem_we;
  logic [TAG_WIDTH-1:0] mem_waddr;
  logic                 mem_wdata;
  logic [TAG_WIDTH-1:0] mem_raddr;
  logic                 mem_rdata;

  logic [TAG_WIDTH-1:0] used;
  logic [TAG_WIDTH-1:0] tag_off;
  logic                 full;
  logic                 tag_busy;
  logic                 walk_bit;

  swta_map #(
    .ADDR_W (TAG_WIDTH)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Window occupancy and membership of the captured tag.
  assign used     = next_r - oldest_r;
  assign tag_off  = tag_r - oldest_r;
  assign full     = (used > TAG_WINDOW);
  assign tag_busy = (tag_off < used) && mem_rdata;

  // The freed tag may be read back before its clear lands; forward the zero.
  assign walk_bit = (rd_addr_r == tag_r) ? 1'b0 : mem_rdata;

  // Sequencer: execute one command, then walk the oldest pointer on a free.
  always_comb begin
    state_nxt      = state_r;
    next_nxt       = next_r;
    oldest_nxt     = oldest_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;
    mem_waddr      = tag_r;
    mem_wdata      = 1'b0;
    mem_raddr      = oldest_r;
    case (state_r)
      S_IDLE: begin
        mem_raddr = in_word.tag_in[TAG_WIDTH-1:0];
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_strobe_nxt       = 1'b1;
        out_word_nxt.tag_out = TAG_FIELD_W'(tag_r);
        state_nxt            = S_IDLE;
        case (func_r)
          FUNC_ALLOC: begin
            if (full) begin
              out_word_nxt.status = ST_FULL;
            end else begin
              mem_we               = 1'b1;
              mem_waddr            = next_r;
              mem_wdata            = 1'b1;
              out_word_nxt.tag_out = TAG_FIELD_W'(next_r);
              out_word_nxt.status  = ST_OK;
              next_nxt             = next_r + 1'b1;
            end
          end
          FUNC_FREE: begin
            out_word_nxt.status = tag_busy ? ST_OK : ST_INCONSISTENT;
            mem_we              = 1'b1;
            mem_waddr           = tag_r;
            mem_wdata           = 1'b0;
            mem_raddr           = oldest_r;
            state_nxt           = S_WALK;
          end
          default: begin
            out_word_nxt.status = tag_busy ? ST_OK : ST_NOT_OUTSTANDING;
          end
        endcase
      end
      S_WALK: begin
        if ((oldest_r == next_r) || walk_bit) begin
          state_nxt = S_IDLE;
        end else begin
          oldest_nxt = oldest_r + 1'b1;
          mem_raddr  = oldest_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_r       <= '0;
      oldest_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_r       <= next_nxt;
      oldest_r     <= oldest_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Captured command word, result word and the address of the read data.
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    rd_addr_r  <= mem_raddr;
    if ((state_r == S_IDLE) && start) begin
      func_r <= in_word.func;
      tag_r  <= in_word.tag_in[TAG_WIDTH-1:0];
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// File: rtl/core/swta_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swta_chk: port checker for the sliding-window tag allocator
// Watches the command and result ports for timing slips of the sequencer.
// ----------------------------------------------------------------------------
module swta_chk
  import swta_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input swta_in_t  in_word,
  input logic      out_strobe,
  input swta_out_t out_word
);

  // A taken word makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a word was taken");

  // Every taken word yields its result strobe after the execute state.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result strobe missing two cycles after a taken word");

  // Results never come in two adjacent cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // A result follows a cycle in which the block was busy with a word.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a word in progress");

  // A full-window result is reported once the block is no longer busy.
  a_full_no_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_word.status == ST_FULL)) |-> !busy)
    else $error("full status reported while the block stays busy");

endmodule

bind sliding_window_tag_allocator swta_chk u_swta_chk (.*);

// File: tb/sv/tb_sliding_window_tag_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_tag_allocator: self-checking bench of the tag allocator
// Drives allocate, free and check commands through the start/busy handshake
// and compares every result word with a tag-window predictor that the bench
// keeps alongside the block. A directed opening covers double frees, checks of
// idle tags, release walks and the unused operation code. Random phases with
// and without sender gaps follow, each ending with a pause for all results.
// ----------------------------------------------------------------------------
module tb_sliding_window_tag_allocator;
  import swta_pkg::*;

  localparam int TAG_W = 16;
  localparam int TAG_COUNT = 1 << TAG_W;
  localparam int unsigned TAG_WINDOW = (TAG_COUNT - 1) / 4;

  // The spare operation code, which the block treats as a check.
  localparam logic [1:0] FUNC_CHECK_ALT = 2'd3;

  // Clock, reset and block ports.
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  swta_in_t  in_word = '0;
  logic      out_strobe;
  swta_out_t out_word;

  // Commands waiting to be driven and result words still to come.
  swta_in_t  cmd_queue[$];
  swta_out_t expected_results[$];

  // Tag-window state as the bench predicts it.
  bit               tag_busy [0:TAG_COUNT-1];
  logic [TAG_W-1:0] next_ptr = '0;
  logic [TAG_W-1:0] oldest_ptr = '0;

  // Run statistics.
  int unsigned sender_gap_pct = 0;
  int unsigned cmd_count = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned issued_count = 0;
  int unsigned refused_count = 0;
  int unsigned bad_free_count = 0;
  int unsigned wrap_count = 0;
  int unsigned longest_walk = 0;

  swta_out_t want;

  sliding_window_tag_allocator #(
    .TAG_WIDTH(TAG_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Number of tags between the oldest outstanding tag and the next to issue.
  function automatic int unsigned window_used();
    logic [TAG_W-1:0] d;
    d = next_ptr - oldest_ptr;
    return 32'(d);
  endfunction

  // Apply one command word to the predicted tag window and return its result.
  function automatic swta_out_t tag_window_predict(swta_in_t w);
    swta_out_t        r;
    logic [TAG_W-1:0] t;
    int unsigned      steps;
    t = w.tag_in[TAG_W-1:0];
    steps = 0;
    r = '0;
    r.tag_out[TAG_W-1:0] = t;
    r.status = ST_OK;
    if (w.func == FUNC_ALLOC) begin
      if (window_used() > TAG_WINDOW) begin
        r.status = ST_FULL;
        refused_count++;
      end else begin
        if (tag_busy[next_ptr]) r.status = ST_INCONSISTENT;
        tag_busy[next_ptr] = 1'b1;
        r.tag_out = '0;
        r.tag_out[TAG_W-1:0] = next_ptr;
        next_ptr = next_ptr + 1'b1;
        issued_count++;
        if (next_ptr == '0) wrap_count++;
      end
    end else if (w.func == FUNC_FREE) begin
      if (!tag_busy[t]) begin
        r.status = ST_INCONSISTENT;
        bad_free_count++;
      end
      tag_busy[t] = 1'b0;
      // The oldest pointer slides over released tags up to the next busy one.
      while (!tag_busy[oldest_ptr] && oldest_ptr != next_ptr) begin
        oldest_ptr = oldest_ptr + 1'b1;
        steps++;
      end
      if (steps > longest_walk) longest_walk = steps;
    end else begin
      r.status = tag_busy[t] ? ST_OK : ST_NOT_OUTSTANDING;
    end
    return r;
  endfunction

  // Driver: predict each accepted word, then present the next one unless a
  // random sender gap is due.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_results.push_back(tag_window_predict(in_word));
        cmd_count++;
      end
      if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        in_word <= cmd_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Count a failure and describe the first few.
  task automatic flag_mismatch(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s at %0t: expected %h, got %h", what, $realtime, exp_v, act_v);
  endtask

  // Monitor: every strobed result word is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result word", '0, out_word.tag_out);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_word.tag_out !== want.tag_out)
          flag_mismatch("tag_out", want.tag_out, out_word.tag_out);
        if (out_word.status !== want.status)
          flag_mismatch("status", {14'd0, want.status}, {14'd0, out_word.status});
      end
    end
  end

  // Queue one command and wait until the block has taken it.
  task automatic issue(input logic [1:0] f, input logic [15:0] t);
    swta_in_t w;
    w.func = f;
    w.tag_in = t;
    cmd_queue.push_back(w);
    do @(negedge clk); while (cmd_queue.size() != 0 || start);
  endtask

  // Hold the sender until every outstanding result word has come back.
  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // A random busy tag inside the window; the oldest tag is always busy
  // while the window is not empty.
  function automatic logic [TAG_W-1:0] pick_outstanding();
    int unsigned      used;
    int unsigned      off;
    logic [TAG_W-1:0] t;
    used = window_used();
    off = $urandom_range(used - 1);
    for (int k = 0; k < used; k++) begin
      t = oldest_ptr + TAG_W'((off + k) % used);
      if (tag_busy[t]) return t;
    end
    return oldest_ptr;
  endfunction

  // Random commands, mostly well formed against the current window.
  task automatic random_phase(input int n, input int unsigned gap_pct);
    int unsigned      pick;
    logic [TAG_W-1:0] t;
    sender_gap_pct = gap_pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40 || (pick < 85 && window_used() == 0)) begin
        issue(FUNC_ALLOC, 16'($urandom));
      end else if (pick < 72) begin
        // Freeing the oldest tag often makes the release walk run.
        t = ($urandom_range(3) == 0) ? oldest_ptr : pick_outstanding();
        issue(FUNC_FREE, 16'(t));
      end else if (pick < 85) begin
        t = oldest_ptr + TAG_W'($urandom_range(window_used() - 1));
        issue($urandom_range(1) ? FUNC_CHECK : FUNC_CHECK_ALT, 16'(t));
      end else begin
        issue(2'($urandom_range(3)), 16'($urandom));
      end
    end
    sender_gap_pct = 0;
    drain_results();
  endtask

  // Stimulus and end of run.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: idle tags, double frees, release walks, spare code.
    issue(FUNC_CHECK, 16'h0000);
    issue(FUNC_FREE, 16'h0000);
    issue(FUNC_CHECK_ALT, 16'hFFFF);
    issue(FUNC_ALLOC, 16'hFFFF);
    issue(FUNC_ALLOC, 16'h0000);
    issue(FUNC_ALLOC, 16'h5555);
    issue(FUNC_ALLOC, 16'hAAAA);
    issue(FUNC_CHECK, 16'h0000);
    issue(FUNC_CHECK_ALT, 16'h0001);
    issue(FUNC_FREE, 16'h0001);
    issue(FUNC_CHECK, 16'h0001);
    issue(FUNC_FREE, 16'h0001);
    issue(FUNC_FREE, 16'h0000);
    issue(FUNC_FREE, 16'h0003);
    issue(FUNC_FREE, 16'h0002);
    issue(FUNC_FREE, 16'h0002);
    issue(FUNC_CHECK, 16'h0002);
    issue(FUNC_CHECK, 16'hFFFF);
    issue(FUNC_FREE, 16'hFFFF);
    issue(FUNC_ALLOC, 16'hAAAA);
    issue(FUNC_CHECK, 16'h5555);
    issue(FUNC_FREE, 16'h0004);
    drain_results();

    random_phase(160, 0);
    random_phase(170, 46);
    random_phase(160, 32);
    random_phase(160, 0);

    drain_results();
    repeat (40) @(posedge clk);
    $display("Run covered %0d commands: %0d tags issued, %0d refused on a full window,",
             cmd_count, issued_count, refused_count);
    $display("%0d frees of idle tags, pointer wraps %0d, longest release walk %0d tags.",
             bad_free_count, wrap_count, longest_walk);
    $display("%0d result words checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_sliding_window_tag_allocator OK");
    end else begin
      $display("tb_sliding_window_tag_allocator NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("Timeout with %0d result words still expected.", expected_results.size());
    $display("tb_sliding_window_tag_allocator NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/core/swta_pkg.sv
rtl/core/swta_map.sv
rtl/core/sliding_window_tag_allocator.sv
rtl/core/swta_chk.sv
tb/sv/tb_sliding_window_tag_allocator.sv
